FILE: design/slxfp_pkg.sv
// Package for the sync/length/XOR frame parser.
// Holds the parse phase type, status and kind codes and the framing constants.
// No dependencies.
`default_nettype none

package slxfp_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND     = 8'h75;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd1024;
  localparam int          FRAME_OVERHEAD  = 7;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SYNC2    = 3'd1,
    PH_CMD      = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_LEN_LO   = 3'd4,
    PH_RESERVED = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_CHECK    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

endpackage

`default_nettype wire

FILE: design/sync_length_xor_frame_parser.sv
// Top level of the sync/length/XOR frame parser.
// Depends on slxfp_pkg for the phase type, codes and constants.
//
//   Channel  Ports                         Direction  Moves
//   in       in_valid/in_ready/in_rx_byte  in         one received byte per request
//   out      out_valid/out_ready/out_*     out        payload byte or frame-end verdict
//   cfg      cfg_wr_en/cfg_wr_data         in         maximum payload length
//
// Each byte is parsed in the cycle it is accepted, one byte per cycle while in_ready is high.
// Any result appears in the output register on the following cycle.
// A new byte is taken whenever the output register is empty or being drained,
// so a stalled output holds back input only while a result is waiting.
// Reset returns the parser to hunting and sets the maximum length to 1024.
`default_nettype none

module sync_length_xor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_command_code,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_payload_index,
  output logic [15:0]      out_frame_length,
  output logic [1:0]       out_frame_status,
  output logic             out_last_of_frame,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  slxfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic [15:0] payload_count_r, payload_count_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [15:0] max_len_r;

  logic        out_valid_r, out_valid_nxt;
  logic        emit;
  logic        kind_nxt;
  logic [7:0]  data_nxt;
  logic [15:0] index_nxt;
  logic [1:0]  status_nxt;
  logic        in_fire;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  logic        kind_r;
  logic [7:0]  cmd_out_r;
  logic [7:0]  data_r;
  logic [15:0] index_r;
  logic [15:0] length_out_r;
  logic [1:0]  status_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign len_full  = {held_length_r[15:8], in_rx_byte};
  assign count_inc = payload_count_r + 16'd1;

  always_comb begin
    phase_nxt         = phase_r;
    held_command_nxt  = held_command_r;
    held_length_nxt   = held_length_r;
    payload_count_nxt = payload_count_r;
    running_xor_nxt   = running_xor_r;
    emit              = 1'b0;
    kind_nxt          = slxfp_pkg::KIND_PAYLOAD;
    data_nxt          = 8'd0;
    index_nxt         = 16'd0;
    status_nxt        = slxfp_pkg::STATUS_OK;
    case (phase_r)
      slxfp_pkg::PH_HUNT: begin
        if (in_rx_byte == slxfp_pkg::SYNC_FIRST) begin
          running_xor_nxt = in_rx_byte;
          phase_nxt       = slxfp_pkg::PH_SYNC2;
        end
      end
      slxfp_pkg::PH_SYNC2: begin
        if (in_rx_byte == slxfp_pkg::SYNC_SECOND) begin
          running_xor_nxt = slxfp_pkg::SYNC_FIRST ^ slxfp_pkg::SYNC_SECOND;
          phase_nxt       = slxfp_pkg::PH_CMD;
        end else if (in_rx_byte == slxfp_pkg::SYNC_FIRST) begin
          running_xor_nxt = in_rx_byte;
        end else begin
          phase_nxt = slxfp_pkg::PH_HUNT;
        end
      end
      slxfp_pkg::PH_CMD: begin
        held_command_nxt  = in_rx_byte;
        held_length_nxt   = 16'd0;
        payload_count_nxt = 16'd0;
        running_xor_nxt   = running_xor_r ^ in_rx_byte;
        phase_nxt         = slxfp_pkg::PH_LEN_HI;
      end
      slxfp_pkg::PH_LEN_HI: begin
        held_length_nxt = {in_rx_byte, 8'd0};
        running_xor_nxt = running_xor_r ^ in_rx_byte;
        phase_nxt       = slxfp_pkg::PH_LEN_LO;
      end
      slxfp_pkg::PH_LEN_LO: begin
        held_length_nxt = len_full;
        running_xor_nxt = running_xor_r ^ in_rx_byte;
        if (len_full > max_len_r) begin
          emit       = 1'b1;
          kind_nxt   = slxfp_pkg::KIND_VERDICT;
          status_nxt = slxfp_pkg::STATUS_TOO_LONG;
          phase_nxt  = slxfp_pkg::PH_HUNT;
        end else begin
          phase_nxt = slxfp_pkg::PH_RESERVED;
        end
      end
      slxfp_pkg::PH_RESERVED: begin
        running_xor_nxt   = running_xor_r ^ in_rx_byte;
        payload_count_nxt = 16'd0;
        phase_nxt         = (held_length_r == 16'd0) ? slxfp_pkg::PH_CHECK
                                                     : slxfp_pkg::PH_PAYLOAD;
      end
      slxfp_pkg::PH_PAYLOAD: begin
        running_xor_nxt   = running_xor_r ^ in_rx_byte;
        emit              = 1'b1;
        data_nxt          = in_rx_byte;
        index_nxt         = payload_count_r;
        payload_count_nxt = count_inc;
        if (count_inc >= held_length_r) begin
          phase_nxt = slxfp_pkg::PH_CHECK;
        end
      end
      slxfp_pkg::PH_CHECK: begin
        emit       = 1'b1;
        kind_nxt   = slxfp_pkg::KIND_VERDICT;
        status_nxt = (in_rx_byte == running_xor_r) ? slxfp_pkg::STATUS_OK
                                                   : slxfp_pkg::STATUS_CSUM_ERR;
        phase_nxt  = slxfp_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = slxfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= slxfp_pkg::PH_HUNT;
      held_command_r  <= 8'd0;
      held_length_r   <= 16'd0;
      payload_count_r <= 16'd0;
      running_xor_r   <= 8'd0;
      max_len_r       <= slxfp_pkg::MAX_LEN_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r         <= phase_nxt;
        held_command_r  <= held_command_nxt;
        held_length_r   <= held_length_nxt;
        payload_count_r <= payload_count_nxt;
        running_xor_r   <= running_xor_nxt;
      end
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_r       <= kind_nxt;
      cmd_out_r    <= held_command_nxt;
      data_r       <= data_nxt;
      index_r      <= index_nxt;
      length_out_r <= held_length_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_command_code  = cmd_out_r;
  assign out_payload_byte  = data_r;
  assign out_payload_index = index_r;
  assign out_frame_length  = length_out_r;
  assign out_frame_status  = status_r;
  assign out_last_of_frame = kind_r;

  // The checksum byte always closes the frame with a verdict and a return to hunting.
  a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == slxfp_pkg::PH_CHECK) |=>
      (phase_r == slxfp_pkg::PH_HUNT && out_valid_r
       && out_result_kind == slxfp_pkg::KIND_VERDICT))
    else $error("checksum byte did not close the frame");

  // A payload byte result always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_kind == slxfp_pkg::KIND_PAYLOAD) |->
      (out_payload_index < out_frame_length))
    else $error("payload index beyond declared length");

  // While taking payload, the count never reaches the declared length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == slxfp_pkg::PH_PAYLOAD) |-> (payload_count_r < held_length_r))
    else $error("payload count ran past length");

  // A too-long verdict only reports a length above the maximum.
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && status_nxt == slxfp_pkg::STATUS_TOO_LONG) |->
      (held_length_nxt > max_len_r))
    else $error("too-long verdict for an allowed length");

endmodule

`default_nettype wire
